// ===== hdl/scfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types and constants of the sum-checked frame deframer.
// ----------------------------------------------------------------------------
package scfd_pkg;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_MAX_PAYLOAD_LEN = 1'd0;
  localparam logic [23:0] MAX_PAYLOAD_LEN_RST = 24'd65536;

  // framing
  localparam logic [7:0]  MARKER_LO    = 8'hFF;
  localparam logic [7:0]  MARKER_HI    = 8'hFE;
  localparam logic [31:0] LEN_OVERHEAD = 32'd6;

  // record kinds
  localparam logic [1:0] REC_HEADER = 2'd0;
  localparam logic [1:0] REC_DATA   = 2'd1;
  localparam logic [1:0] REC_END    = 2'd2;

  // end-of-frame status
  localparam logic [1:0] ST_GOOD   = 2'd0;
  localparam logic [1:0] ST_BADSUM = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] command_code;
    logic [23:0] payload_count;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [1:0]  frame_status;
  } rec_t;

endpackage

// ===== hdl/scfd_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_byte_if
// Received byte stream channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/scfd_rec_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_rec_if
// Deframed record channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scfd_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [15:0] command_code;
  logic [23:0] payload_count;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [1:0]  frame_status;

  modport source (
    output valid, output record_kind, output command_code, output payload_count,
    output payload_byte, output payload_last, output frame_status, input ready
  );
  modport sink (
    input valid, input record_kind, input command_code, input payload_count,
    input payload_byte, input payload_last, input frame_status, output ready
  );
endinterface

// ===== hdl/sum_checked_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_checked_frame_deframer_core
// Parses FF FE marked, length prefixed frames with an additive checksum.
// ----------------------------------------------------------------------------
// Takes one byte per clock whenever input ready is high, with no gaps between
// frames. Each byte updates the parser state in the cycle it is accepted; a
// record it produces (header, payload byte or end of frame) is registered into
// the output word register, or into the skid stage while the output register
// holds a word not yet taken. The one-word skid stage keeps input ready
// independent of out_if.ready; input ready drops only while both hold a
// word. max_payload_len is sampled when the fourth length byte arrives.
module sum_checked_frame_deframer_core #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  scfd_byte_if.sink                       in_if,
  scfd_rec_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scfd_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;

  // config register
  logic [23:0] max_len_r;
  logic        reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[scfd_pkg::ADDR_W-1:2] == scfd_pkg::REG_MAX_PAYLOAD_LEN);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {8'd0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= scfd_pkg::MAX_PAYLOAD_LEN_RST;
    end else if (cfg_wr) begin
      max_len_r <= pwdata[23:0];
    end
  end

  // parser state
  logic [2:0]             phase_r, phase_nxt;
  logic                   saw_ff_r, saw_ff_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [23:0]            len_r, len_nxt;
  logic [7:0]             cmd_lo_r, cmd_lo_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [31:0]            sum_r, sum_nxt;
  logic [23:0]            rsum_r, rsum_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic [31:0]            len_full;
  logic [31:0]            pay_len;
  logic                   len_bad;
  logic [COUNT_WIDTH-1:0] rem_dec;
  logic [31:0]            rem_ext;
  logic [31:0]            rsum_full;
  logic                   push;
  scfd_pkg::rec_t         push_rec;

  assign accept    = in_if.valid && in_if.ready;
  assign b         = in_if.rx_byte;
  assign len_full  = {b, len_r};
  assign pay_len   = len_full - scfd_pkg::LEN_OVERHEAD;
  assign len_bad   = (len_full < scfd_pkg::LEN_OVERHEAD) ||
                     (pay_len > {8'd0, max_len_r}) ||
                     ((64'(pay_len) >> COUNT_WIDTH) != 64'd0);
  assign rem_dec   = rem_r - COUNT_WIDTH'(1);
  assign rem_ext   = 32'(rem_r);
  assign rsum_full = {b, rsum_r};

  always_comb begin
    phase_nxt  = phase_r;
    saw_ff_nxt = saw_ff_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    cmd_lo_nxt = cmd_lo_r;
    rem_nxt    = rem_r;
    sum_nxt    = sum_r;
    rsum_nxt   = rsum_r;
    push       = 1'b0;
    push_rec   = '0;
    case (phase_r)
      PH_LEN: begin
        case (idx_r)
          2'd0:    len_nxt[7:0]   = b;
          2'd1:    len_nxt[15:8]  = b;
          2'd2:    len_nxt[23:16] = b;
          default: len_nxt        = len_r;
        endcase
        if (idx_r != 2'd3) begin
          idx_nxt = idx_r + 2'd1;
        end else begin
          idx_nxt = 2'd0;
          if (len_bad) begin
            phase_nxt              = PH_HUNT;
            saw_ff_nxt             = 1'b0;
            push                   = 1'b1;
            push_rec.record_kind   = scfd_pkg::REC_END;
            push_rec.frame_status  = scfd_pkg::ST_BADLEN;
          end else begin
            rem_nxt   = pay_len[COUNT_WIDTH-1:0];
            phase_nxt = PH_CMD;
          end
        end
      end
      PH_CMD: begin
        if (idx_r == 2'd0) begin
          cmd_lo_nxt = b;
          idx_nxt    = 2'd1;
        end else begin
          idx_nxt                = 2'd0;
          sum_nxt                = 32'd0;
          phase_nxt              = (rem_r == '0) ? PH_SUM : PH_DATA;
          push                   = 1'b1;
          push_rec.record_kind   = scfd_pkg::REC_HEADER;
          push_rec.command_code  = {b, cmd_lo_r};
          push_rec.payload_count = rem_ext[23:0];
        end
      end
      PH_DATA: begin
        sum_nxt               = sum_r + 32'(b);
        rem_nxt               = rem_dec;
        push                  = 1'b1;
        push_rec.record_kind  = scfd_pkg::REC_DATA;
        push_rec.payload_byte = b;
        push_rec.payload_last = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_nxt = PH_SUM;
          idx_nxt   = 2'd0;
        end
      end
      PH_SUM: begin
        case (idx_r)
          2'd0:    rsum_nxt[7:0]   = b;
          2'd1:    rsum_nxt[15:8]  = b;
          2'd2:    rsum_nxt[23:16] = b;
          default: rsum_nxt        = rsum_r;
        endcase
        if (idx_r != 2'd3) begin
          idx_nxt = idx_r + 2'd1;
        end else begin
          phase_nxt             = PH_HUNT;
          saw_ff_nxt            = 1'b0;
          idx_nxt               = 2'd0;
          push                  = 1'b1;
          push_rec.record_kind  = scfd_pkg::REC_END;
          push_rec.frame_status = (rsum_full == sum_r) ? scfd_pkg::ST_GOOD
                                                       : scfd_pkg::ST_BADSUM;
        end
      end
      default: begin
        if (saw_ff_r && (b == scfd_pkg::MARKER_HI)) begin
          phase_nxt  = PH_LEN;
          saw_ff_nxt = 1'b0;
          idx_nxt    = 2'd0;
        end else begin
          phase_nxt  = PH_HUNT;
          saw_ff_nxt = (b == scfd_pkg::MARKER_LO);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      saw_ff_r <= 1'b0;
      idx_r    <= 2'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      saw_ff_r <= saw_ff_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      len_r    <= len_nxt;
      cmd_lo_r <= cmd_lo_nxt;
      rem_r    <= rem_nxt;
      sum_r    <= sum_nxt;
      rsum_r   <= rsum_nxt;
    end
  end

  // output word register plus skid stage
  logic           out_v_r;
  logic           skid_v_r;
  scfd_pkg::rec_t out_r;
  scfd_pkg::rec_t skid_r;
  logic           load_out;
  logic           push_acc;

  assign in_if.ready = !skid_v_r;
  assign load_out    = !out_v_r || out_if.ready;
  assign push_acc    = accept && push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r  <= skid_v_r || push_acc;
      skid_v_r <= 1'b0;
    end else if (push_acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= skid_v_r ? skid_r : push_rec;
    end else if (push_acc) begin
      skid_r <= push_rec;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.record_kind   = out_r.record_kind;
  assign out_if.command_code  = out_r.command_code;
  assign out_if.payload_count = out_r.payload_count;
  assign out_if.payload_byte  = out_r.payload_byte;
  assign out_if.payload_last  = out_r.payload_last;
  assign out_if.frame_status  = out_r.frame_status;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage holds a word while output register is empty");

  a_last_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (phase_r == PH_DATA) && (rem_r == COUNT_WIDTH'(1))) |=>
      (phase_r == PH_SUM))
    else $error("final payload byte did not move parser to checksum");

  a_data_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> ((idx_r == 2'd0) && (rem_r != '0)))
    else $error("payload phase entered with stale index or zero count");

endmodule
